// ===== design/layer_blend_compositor_defines.svh =====
// assertion macros for the layer blend compositor checker
// expects clk and arst_n in the scope of each use
`ifndef LAYER_BLEND_COMPOSITOR_DEFINES_SVH
`define LAYER_BLEND_COMPOSITOR_DEFINES_SVH

// same-cycle implication
`define LBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lbc_pkg.sv =====
// shared types and constants of the layer blend compositor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

	localparam int FIELD_LAYERS = 6;
	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int OP_W = 7;
	localparam int SUM_W = 15;
	localparam int DIV100_MUL_W = 13;
	localparam int DIV100_SHIFT = 19;

	localparam logic [OP_W-1:0] OPACITY_FULL = 7'd100;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_ENABLE = 3'd0;
	localparam cfg_idx_t REG_MODES = 3'd1;
	localparam cfg_idx_t REG_OPACITY0 = 3'd2;

	typedef logic [2:0][CH_W-1:0] rgb_t;
	localparam rgb_t WHITE = {3{8'hFF}};

	typedef enum logic [3:0] {
		MODE_NORMAL     = 4'd0,
		MODE_AVERAGE    = 4'd1,
		MODE_MULTIPLY   = 4'd2,
		MODE_SCREEN     = 4'd3,
		MODE_DARKEN     = 4'd4,
		MODE_LIGHTEN    = 4'd5,
		MODE_DIFFERENCE = 4'd6,
		MODE_OVERLAY    = 4'd7,
		MODE_HARD_LIGHT = 4'd8,
		MODE_SUM        = 4'd9,
		MODE_XOR        = 4'd10,
		MODE_AND        = 4'd11,
		MODE_OR         = 4'd12
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [OP_W-1:0] op;
	} layer_cfg_t;

endpackage

`default_nettype wire

// ===== design/lbc_if.sv =====
// valid/ready channel interfaces for pixel beats in and result beats out
// depends on lbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lbc_in_if;
	logic valid;
	logic ready;
	logic [lbc_pkg::PIX_W-1:0] layer0_rgb;
	logic [lbc_pkg::PIX_W-1:0] layer1_rgb;
	logic [lbc_pkg::PIX_W-1:0] layer2_rgb;
	logic [lbc_pkg::PIX_W-1:0] layer3_rgb;
	logic [lbc_pkg::PIX_W-1:0] layer4_rgb;
	logic [lbc_pkg::PIX_W-1:0] layer5_rgb;

	modport source (
		output valid, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb, layer4_rgb,
			layer5_rgb,
		input ready
	);
	modport sink (
		input valid, layer0_rgb, layer1_rgb, layer2_rgb, layer3_rgb, layer4_rgb,
			layer5_rgb,
		output ready
	);
endinterface

interface lbc_out_if;
	logic valid;
	logic ready;
	logic [lbc_pkg::CH_W-1:0] red_out;
	logic [lbc_pkg::CH_W-1:0] green_out;
	logic [lbc_pkg::CH_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== design/lbc_cell.sv =====
// one layer cell: blend mix, opacity multiply-add, divide by 100
// three register stages with bubble-collapsing flow control; depends on lbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbc_cell #(
	parameter int LAYER_COUNT = 6,
	parameter int LAYER = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire lbc_pkg::layer_cfg_t cfg,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire lbc_pkg::rgb_t base_in,
	input  wire logic [LAYER_COUNT-1:0][lbc_pkg::PIX_W-1:0] pix_in,
	output logic out_valid,
	input  wire logic out_ready,
	output lbc_pkg::rgb_t base_out,
	output logic [LAYER_COUNT-1:0][lbc_pkg::PIX_W-1:0] pix_out
);

	localparam int CW = lbc_pkg::CH_W;
	localparam int SW = lbc_pkg::SUM_W;
	localparam int QW = SW + lbc_pkg::DIV100_MUL_W;

	logic valid_s1, valid_s2, valid_s3;
	logic ld1, ld2, ld3;

	lbc_pkg::rgb_t top;
	lbc_pkg::rgb_t mix;
	lbc_pkg::rgb_t base_s1, mix_s1, base_s3;
	logic [2:0][SW-1:0] sum;
	logic [2:0][SW-1:0] sum_s2;
	lbc_pkg::rgb_t quot;
	logic [LAYER_COUNT-1:0][lbc_pkg::PIX_W-1:0] pix_s1, pix_s2, pix_s3;

	assign top = lbc_pkg::rgb_t'(pix_in[LAYER]);

	assign ld3 = !valid_s3 || out_ready;
	assign ld2 = !valid_s2 || ld3;
	assign ld1 = !valid_s1 || ld2;
	assign in_ready = ld1;

	// blend mix, one shared multiplier per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [CW-1:0] b, t, x, y, s, pv;
			logic [2*CW-1:0] p;
			logic [CW:0] add;
			logic inv, sh7;
			b = base_in[c];
			t = top[c];
			inv = 1'b0;
			sh7 = 1'b0;
			case (cfg.mode)
				lbc_pkg::MODE_SCREEN: inv = 1'b1;
				lbc_pkg::MODE_OVERLAY: begin
					sh7 = 1'b1;
					inv = b[CW-1];
				end
				lbc_pkg::MODE_HARD_LIGHT: begin
					sh7 = 1'b1;
					inv = t[CW-1];
				end
				default: ;
			endcase
			x = inv ? ~b : b;
			y = inv ? ~t : t;
			p = (2*CW)'(x) * (2*CW)'(y);
			s = sh7 ? p[2*CW-2:CW-1] : p[2*CW-1:CW];
			pv = inv ? ~s : s;
			add = {1'b0, b} + {1'b0, t};
			case (cfg.mode)
				lbc_pkg::MODE_AVERAGE:    mix[c] = add[CW:1];
				lbc_pkg::MODE_MULTIPLY,
				lbc_pkg::MODE_SCREEN,
				lbc_pkg::MODE_OVERLAY,
				lbc_pkg::MODE_HARD_LIGHT: mix[c] = pv;
				lbc_pkg::MODE_DARKEN:     mix[c] = (b < t) ? b : t;
				lbc_pkg::MODE_LIGHTEN:    mix[c] = (b > t) ? b : t;
				lbc_pkg::MODE_DIFFERENCE: mix[c] = (b > t) ? b - t : t - b;
				lbc_pkg::MODE_SUM:        mix[c] = add[CW-1:0];
				lbc_pkg::MODE_XOR:        mix[c] = b ^ t;
				lbc_pkg::MODE_AND:        mix[c] = b & t;
				lbc_pkg::MODE_OR:         mix[c] = b | t;
				default:                  mix[c] = t;
			endcase
		end
	end

	// base*100 + op*(mix-base), never negative
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic signed [CW:0] d;
			logic signed [CW+lbc_pkg::OP_W+1:0] pr;
			logic [SW-1:0] b100;
			logic signed [CW+lbc_pkg::OP_W+1:0] tot;
			d = $signed({1'b0, mix_s1[c]}) - $signed({1'b0, base_s1[c]});
			pr = $signed({1'b0, cfg.op}) * d;
			b100 = SW'(base_s1[c]) * SW'(lbc_pkg::OPACITY_FULL);
			tot = $signed({2'b00, b100}) + pr;
			sum[c] = tot[SW-1:0];
		end
	end

	// floor division by 100 through a reciprocal, exact below 25600
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [QW-1:0] qp;
			qp = QW'(sum_s2[c]) * QW'(lbc_pkg::DIV100_MUL);
			quot[c] = qp[lbc_pkg::DIV100_SHIFT +: CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= in_valid;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			base_s1 <= base_in;
			mix_s1 <= mix;
			pix_s1 <= pix_in;
		end
		if (ld2 && valid_s1) begin
			sum_s2 <= sum;
			pix_s2 <= pix_s1;
		end
		if (ld3 && valid_s2) begin
			base_s3 <= quot;
			pix_s3 <= pix_s2;
		end
	end

	assign out_valid = valid_s3;
	assign base_out = base_s3;
	assign pix_out = pix_s3;

endmodule

`default_nettype wire

// ===== design/layer_blend_compositor.sv =====
// top level of the layer blend compositor: config registers and the cell chain
// depends on lbc_pkg, lbc_if and lbc_cell
`timescale 1ns / 1ps
`default_nettype none

// Composites six RGB layers over white, bottom layer first, each with its blend
// mode and percent opacity. One pixel beat is taken and one result beat leaves
// every clock while the result side does not stall. There are three register
// stages per layer cell (blend multiplier, opacity multiply-add, reciprocal divide by 100).
// Stalls on the result side fill empty stages before the pixel side is held.
// Write layer_enable, layer_modes and opacity_0..5 through cfg_wen/cfg_index/
// cfg_data only while no beat is in flight; opacity above 100 counts as 100.

module layer_blend_compositor #(
	parameter int LAYER_COUNT = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lbc_in_if.sink pixels,
	lbc_out_if.source result,
	input  wire logic cfg_wen,
	input  wire lbc_pkg::cfg_idx_t cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int FL = lbc_pkg::FIELD_LAYERS;
	localparam int OPW = lbc_pkg::OP_W;

	logic [FL-1:0] enable_q;
	logic [4*FL-1:0] modes_q;
	logic [OPW-1:0] opacity_q [FL];
	logic [OPW-1:0] op_sat [FL];

	logic [FL-1:0][lbc_pkg::PIX_W-1:0] fields;
	logic [LAYER_COUNT:0][LAYER_COUNT-1:0][lbc_pkg::PIX_W-1:0] pix_c;
	lbc_pkg::rgb_t base_c [LAYER_COUNT+1];
	logic [LAYER_COUNT:0] valid_c;
	logic [LAYER_COUNT:0] ready_c;
	lbc_pkg::layer_cfg_t cfg_c [LAYER_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			modes_q <= '0;
			for (int i = 0; i < FL; i++) opacity_q[i] <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				lbc_pkg::REG_ENABLE: enable_q <= cfg_data[FL-1:0];
				lbc_pkg::REG_MODES: modes_q <= cfg_data[4*FL-1:0];
				default: opacity_q[3'(cfg_index - lbc_pkg::REG_OPACITY0)] <= cfg_data[OPW-1:0];
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < FL; i++)
			op_sat[i] = (opacity_q[i] > lbc_pkg::OPACITY_FULL) ? lbc_pkg::OPACITY_FULL
				: opacity_q[i];
	end

	assign fields[0] = pixels.layer0_rgb;
	assign fields[1] = pixels.layer1_rgb;
	assign fields[2] = pixels.layer2_rgb;
	assign fields[3] = pixels.layer3_rgb;
	assign fields[4] = pixels.layer4_rgb;
	assign fields[5] = pixels.layer5_rgb;

	for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_pix
		if (i < FL) begin : g_field
			assign pix_c[0][i] = fields[i];
		end else begin : g_none
			assign pix_c[0][i] = '0;
		end
	end

	assign base_c[0] = lbc_pkg::WHITE;
	assign valid_c[0] = pixels.valid;
	assign pixels.ready = ready_c[0];

	// cell j handles layer LAYER_COUNT-1-j, so layer 0 is applied last
	for (genvar j = 0; j < LAYER_COUNT; j++) begin : g_cell
		localparam int L = LAYER_COUNT - 1 - j;
		if (L < FL) begin : g_cfg
			assign cfg_c[j].mode = lbc_pkg::mode_t'(modes_q[4*L +: 4]);
			assign cfg_c[j].op = enable_q[L] ? op_sat[L] : '0;
		end else begin : g_off
			assign cfg_c[j].mode = lbc_pkg::MODE_NORMAL;
			assign cfg_c[j].op = '0;
		end

		lbc_cell #(
			.LAYER_COUNT(LAYER_COUNT),
			.LAYER(L)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cfg(cfg_c[j]),
			.in_valid(valid_c[j]),
			.in_ready(ready_c[j]),
			.base_in(base_c[j]),
			.pix_in(pix_c[j]),
			.out_valid(valid_c[j+1]),
			.out_ready(ready_c[j+1]),
			.base_out(base_c[j+1]),
			.pix_out(pix_c[j+1])
		);
	end

	assign result.valid = valid_c[LAYER_COUNT];
	assign ready_c[LAYER_COUNT] = result.ready;
	assign result.red_out = base_c[LAYER_COUNT][2];
	assign result.green_out = base_c[LAYER_COUNT][1];
	assign result.blue_out = base_c[LAYER_COUNT][0];

endmodule

`default_nettype wire

// ===== design/lbc_checker.sv =====
// port-level checks of the layer blend compositor, bound to the top level
// depends on lbc_pkg and layer_blend_compositor_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "layer_blend_compositor_defines.svh"

module lbc_checker #(
	parameter int LAYER_COUNT = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] red_out,
	input wire logic [7:0] green_out,
	input wire logic [7:0] blue_out,
	input wire logic cfg_wen,
	input wire lbc_pkg::cfg_idx_t cfg_index,
	input wire logic [23:0] cfg_data
);

	localparam int DEPTH = 3 * LAYER_COUNT;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int FL = lbc_pkg::FIELD_LAYERS;

	logic [CW-1:0] inflight_q;
	logic [FL-1:0] enable_q;
	logic in_beat, out_beat;

	assign in_beat = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			enable_q <= '0;
		end else begin
			inflight_q <= inflight_q + CW'(in_beat) - CW'(out_beat);
			if (cfg_wen && cfg_index == lbc_pkg::REG_ENABLE) enable_q <= cfg_data[FL-1:0];
		end
	end

	`LBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out),
		"stalled result beat changed")

	`LBC_ASSERT_NOW(a_ready_full, !in_ready, out_valid && !out_ready,
		"input held while the result side is not stalled")

	`LBC_ASSERT_NOW(a_no_phantom, out_valid, inflight_q != '0,
		"result beat without an accepted pixel beat")

	`LBC_ASSERT_NOW(a_white, out_valid && enable_q == '0,
		red_out == 8'hFF && green_out == 8'hFF && blue_out == 8'hFF,
		"no layer enabled but result is not white")

endmodule

bind layer_blend_compositor lbc_checker #(.LAYER_COUNT(LAYER_COUNT)) u_lbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pixels.valid),
	.in_ready(pixels.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.red_out(result.red_out),
	.green_out(result.green_out),
	.blue_out(result.blue_out),
	.cfg_wen(cfg_wen),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data)
);

`default_nettype wire

// ===== dv/layer_blend_compositor_test.sv =====
// self-checking testbench for layer_blend_compositor: random valid/ready pacing on
// both channels, register programming between phases, per-channel compare
// depends on lbc_pkg, lbc_if and layer_blend_compositor
`timescale 1ns / 1ps

module layer_blend_compositor_test;

	localparam int NL = lbc_pkg::FIELD_LAYERS;
	localparam int OPW = lbc_pkg::OP_W;
	localparam int CHW = lbc_pkg::CH_W;

	typedef logic [NL-1:0][lbc_pkg::PIX_W-1:0] pixel_stack_t;

	localparam logic [3:0] MODE_SPARE_13 = 4'd13;
	localparam logic [3:0] MODE_SPARE_14 = 4'd14;
	localparam logic [3:0] MODE_SPARE_15 = 4'd15;
	localparam int RANDOM_PIXELS = 750;
	localparam int PIPE_DEPTH = 3 * NL;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	lbc_pkg::cfg_idx_t cfg_index;
	logic [23:0] cfg_data;

	lbc_in_if pix_bus ();
	lbc_out_if res_bus ();

	layer_blend_compositor #(.LAYER_COUNT(NL)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_bus),
		.result(res_bus),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the block's registers
	logic [NL-1:0] enable_shadow;
	logic [23:0] modes_shadow;
	logic [OPW-1:0] opacity_shadow [NL];

	pixel_stack_t pending_pixels [$];
	lbc_pkg::rgb_t composite_expected [$];
	pixel_stack_t next_stack;
	logic pixel_taken;
	int pixel_gap;
	int stall_len;
	bit pixel_steady;
	bit result_steady;
	int mismatch_count = 0;
	int random_sent;

	function automatic int blend_channel(logic [3:0] mode, int base, int top);
		case (mode)
			lbc_pkg::MODE_AVERAGE: return (base + top) >> 1;
			lbc_pkg::MODE_MULTIPLY: return (base * top) >> 8;
			lbc_pkg::MODE_SCREEN: return 255 - (((255 - base) * (255 - top)) >> 8);
			lbc_pkg::MODE_DARKEN: return (base < top) ? base : top;
			lbc_pkg::MODE_LIGHTEN: return (base > top) ? base : top;
			lbc_pkg::MODE_DIFFERENCE: return (base > top) ? base - top : top - base;
			lbc_pkg::MODE_OVERLAY: return (base < 128) ? (base * top) >> 7
				: 255 - (((255 - base) * (255 - top)) >> 7);
			lbc_pkg::MODE_HARD_LIGHT: return (top < 128) ? (base * top) >> 7
				: 255 - (((255 - top) * (255 - base)) >> 7);
			lbc_pkg::MODE_SUM: return (base + top) & 255;
			lbc_pkg::MODE_XOR: return base ^ top;
			lbc_pkg::MODE_AND: return base & top;
			lbc_pkg::MODE_OR: return base | top;
			default: return top;
		endcase
	endfunction

	function automatic lbc_pkg::rgb_t composite_pixel(pixel_stack_t stack);
		lbc_pkg::rgb_t acc;
		int base;
		int mix;
		int op;
		acc = lbc_pkg::WHITE;
		for (int l = NL - 1; l >= 0; l--) begin
			if (enable_shadow[l]) begin
				op = (opacity_shadow[l] > lbc_pkg::OPACITY_FULL)
					? int'(lbc_pkg::OPACITY_FULL) : int'(opacity_shadow[l]);
				for (int c = 0; c < 3; c++) begin
					base = int'(acc[c]);
					mix = blend_channel(modes_shadow[4*l +: 4], base,
						int'(stack[l][8*c +: 8]));
					acc[c] = CHW'((op * mix + (100 - op) * base) / 100);
				end
			end
		end
		return acc;
	endfunction

	function automatic string channel_name(int c);
		case (c)
			2: return "red_out";
			1: return "green_out";
			default: return "blue_out";
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic logic [CHW-1:0] pick_channel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			3: return 8'd128;
			default: return CHW'($urandom());
		endcase
	endfunction

	function automatic pixel_stack_t random_stack();
		pixel_stack_t stack;
		for (int l = 0; l < NL; l++)
			stack[l] = {pick_channel(), pick_channel(), pick_channel()};
		return stack;
	endfunction

	function automatic logic [OPW-1:0] pick_opacity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 7'd0;
		if (r < 20) return lbc_pkg::OPACITY_FULL;
		if (r < 28) return OPW'($urandom_range(101, 127));
		return OPW'($urandom_range(0, 100));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// pixel beat driver
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
			pix_bus.layer0_rgb <= '0;
			pix_bus.layer1_rgb <= '0;
			pix_bus.layer2_rgb <= '0;
			pix_bus.layer3_rgb <= '0;
			pix_bus.layer4_rgb <= '0;
			pix_bus.layer5_rgb <= '0;
			pixel_gap <= 0;
			pixel_steady = 1'b0;
		end else if (!pix_bus.valid || pixel_taken) begin
			if (pixel_gap > 0) begin
				pixel_gap <= pixel_gap - 1;
				pix_bus.valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				next_stack = pending_pixels.pop_front();
				pix_bus.layer0_rgb <= next_stack[0];
				pix_bus.layer1_rgb <= next_stack[1];
				pix_bus.layer2_rgb <= next_stack[2];
				pix_bus.layer3_rgb <= next_stack[3];
				pix_bus.layer4_rgb <= next_stack[4];
				pix_bus.layer5_rgb <= next_stack[5];
				pix_bus.valid <= 1'b1;
				if ($urandom_range(0, 24) == 0)
					pixel_steady = !pixel_steady;
				pixel_gap <= pixel_steady ? 0 : pick_gap();
			end else begin
				pix_bus.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_len <= 0;
			result_steady = 1'b0;
		end else if (stall_len > 0) begin
			stall_len <= stall_len - 1;
			res_bus.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				result_steady = !result_steady;
			if (!result_steady && $urandom_range(0, 3) == 0) begin
				res_bus.ready <= 1'b0;
				stall_len <= pick_gap();
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// accepted pixel beats become expectations; result beats are checked
	always @(posedge clk) begin
		lbc_pkg::rgb_t want;
		lbc_pkg::rgb_t got;
		if (!arst_n) begin
			pixel_taken <= 1'b0;
		end else begin
			pixel_taken <= pix_bus.valid && pix_bus.ready;
			if (pix_bus.valid && pix_bus.ready)
				composite_expected.push_back(composite_pixel({pix_bus.layer5_rgb,
					pix_bus.layer4_rgb, pix_bus.layer3_rgb, pix_bus.layer2_rgb,
					pix_bus.layer1_rgb, pix_bus.layer0_rgb}));
			if (res_bus.valid && res_bus.ready) begin
				got = {res_bus.red_out, res_bus.green_out, res_bus.blue_out};
				if (composite_expected.size() == 0) begin
					$error("unexpected result beat %h", got);
					mismatch_count++;
				end else begin
					want = composite_expected.pop_front();
					for (int c = 2; c >= 0; c--)
						if (got[c] !== want[c]) begin
							$error("%s: expected %0d, got %0d", channel_name(c), want[c],
								got[c]);
							mismatch_count++;
						end
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || composite_expected.size() != 0
				|| pix_bus.valid)
			@(posedge clk);
	endtask

	task automatic write_reg(lbc_pkg::cfg_idx_t idx, logic [23:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == lbc_pkg::REG_ENABLE)
			enable_shadow = data[NL-1:0];
		else if (idx == lbc_pkg::REG_MODES)
			modes_shadow = data;
		else
			opacity_shadow[idx - lbc_pkg::REG_OPACITY0] = data[OPW-1:0];
	endtask

	// data bits above each register's width are random junk
	task automatic program_layers(logic [NL-1:0] en, logic [23:0] modes,
			logic [NL-1:0][OPW-1:0] ops);
		wait_idle();
		write_reg(lbc_pkg::REG_ENABLE, {18'($urandom()), en});
		write_reg(lbc_pkg::REG_MODES, modes);
		for (int l = 0; l < NL; l++)
			write_reg(lbc_pkg::cfg_idx_t'(lbc_pkg::REG_OPACITY0 + l),
				{17'($urandom()), ops[l]});
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_directed();
		pixel_stack_t stack;
		pending_pixels.push_back('0);
		pending_pixels.push_back('1);
		for (int l = 0; l < NL; l++)
			stack[l] = l[0] ? 24'h7F807F : 24'h807F80;
		pending_pixels.push_back(stack);
		pending_pixels.push_back(random_stack());
	endtask

	initial begin
		logic [NL-1:0][OPW-1:0] ops;
		logic [NL-1:0] en;
		int burst;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = lbc_pkg::REG_ENABLE;
		cfg_data = '0;
		enable_shadow = '0;
		modes_shadow = '0;
		for (int l = 0; l < NL; l++)
			opacity_shadow[l] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers still at reset: nothing shown, white out
		pending_pixels.push_back('0);
		pending_pixels.push_back('1);

		program_layers('1, {lbc_pkg::MODE_SCREEN, lbc_pkg::MODE_MULTIPLY,
			lbc_pkg::MODE_AVERAGE, lbc_pkg::MODE_NORMAL, lbc_pkg::MODE_DARKEN,
			lbc_pkg::MODE_LIGHTEN}, {NL{lbc_pkg::OPACITY_FULL}});
		push_directed();
		program_layers('1, {lbc_pkg::MODE_DIFFERENCE, lbc_pkg::MODE_OVERLAY,
			lbc_pkg::MODE_HARD_LIGHT, lbc_pkg::MODE_SUM, lbc_pkg::MODE_XOR,
			lbc_pkg::MODE_AND}, {lbc_pkg::OPACITY_FULL, 7'd50, 7'd1, 7'd99,
			lbc_pkg::OPACITY_FULL, 7'd73});
		push_directed();
		// reserved mode codes and opacity past full scale
		program_layers('1, {lbc_pkg::MODE_OR, MODE_SPARE_13, MODE_SPARE_14, MODE_SPARE_15,
			lbc_pkg::MODE_OVERLAY, lbc_pkg::MODE_HARD_LIGHT}, {7'd101, 7'd127, 7'd0,
			lbc_pkg::OPACITY_FULL, 7'd110, 7'd64});
		push_directed();
		program_layers(6'b000001, {6{lbc_pkg::MODE_MULTIPLY}}, '0);
		pending_pixels.push_back('0);
		pending_pixels.push_back('1);

		random_sent = 0;
		for (int phase = 0; random_sent < RANDOM_PIXELS; phase++) begin
			for (int l = 0; l < NL; l++)
				ops[l] = pick_opacity();
			en = NL'($urandom());
			if (phase == 0) begin
				en = '1;
				ops = {NL{lbc_pkg::OPACITY_FULL}};
			end else if (phase == 1) begin
				en = '1;
				ops = '0;
			end else if ($urandom_range(0, 7) == 0) begin
				en = '0;
			end else if ($urandom_range(0, 5) == 0) begin
				en = '1;
			end
			program_layers(en, 24'($urandom()), ops);
			burst = $urandom_range(10, 50);
			for (int k = 0; k < burst; k++)
				pending_pixels.push_back(random_stack());
			random_sent += burst;
		end

		wait_idle();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatch_count == 0 && composite_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
